// ----- hdl/rlrc_pkg.sv -----
// Shared types and constants for the revision log replay cursor.
// Depends on nothing; every other file but rlrc_ram imports it.
`default_nettype none
package rlrc_pkg;

    localparam int LOG_DEPTH = 256;
    localparam int ADDR_W    = $clog2(LOG_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int REV_W     = 31;
    localparam int IDX_W     = 9;
    localparam int MODE_W    = 3;
    localparam int STAT_W    = 3;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 120;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND  = 3'd0,
        MODE_DROP    = 3'd1,
        MODE_TRIM    = 3'd2,
        MODE_NEXT    = 3'd3,
        MODE_APPLIED = 3'd4,
        MODE_PENDING = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_NONE    = 3'd0,
        STATUS_READY   = 3'd1,
        STATUS_GAP     = 3'd2,
        STATUS_UNAVAIL = 3'd3,
        STATUS_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic search_init;
        logic rd_mid;
        logic step;
        logic rd_idx;
        logic rd_last;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  search_done;
        logic  trim_zero;
        logic  out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/rlrc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module rlrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/rlrc_ctrl.sv -----
// Controller state machine: sequences decode, binary search probes and commit.
// Depends on rlrc_pkg.
`default_nettype none
module rlrc_ctrl
    import rlrc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (stat.mode)
                    MODE_TRIM: state_next = stat.trim_zero ? ST_COMMIT : ST_SRCH_RD;
                    MODE_NEXT: state_next = ST_SRCH_RD;
                    default:   state_next = ST_COMMIT;
                endcase
            end
            ST_SRCH_RD: begin
                state_next = stat.search_done ? ST_COMMIT : ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                state_next = ST_SRCH_RD;
            end
            ST_COMMIT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            ST_DECODE: begin
                case (stat.mode)
                    MODE_TRIM:    cmd.search_init = !stat.trim_zero;
                    MODE_NEXT:    cmd.search_init = 1'b1;
                    MODE_PENDING: cmd.rd_last     = 1'b1;
                    default:      cmd.search_init = 1'b0;
                endcase
            end
            ST_SRCH_RD: begin
                if (stat.search_done) begin
                    cmd.rd_idx = (stat.mode == MODE_NEXT);
                end else begin
                    cmd.rd_mid = 1'b1;
                end
            end
            ST_SRCH_CMP: begin
                cmd.step = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/rlrc_dp.sv -----
// Datapath: log ring, cursor state, search bounds and the result register.
// Depends on rlrc_pkg and rlrc_ram.
`default_nettype none
module rlrc_dp
    import rlrc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [MODE_W-1:0]   s_tuser,
    input  wire ctrl_cmd_t           cmd,
    output dp_stat_t                 stat,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic      [STAT_W-1:0]   m_tuser
);

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [REV_W-1:0]  cursor_reg, cursor_next;
    logic [REV_W-1:0]  reported_reg, reported_next;
    logic              valid_reg;

    mode_t             mode_reg;
    logic [REV_W-1:0]  rev_reg;
    logic [REV_W-1:0]  maxr_reg;
    logic [IDX_W-1:0]  drop_reg;
    logic [REV_W-1:0]  key_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  mid_reg;

    status_t           o_status;
    logic [IDX_W-1:0]  o_index;
    logic [REV_W-1:0]  o_record;
    logic [REV_W-1:0]  o_expected;
    logic [REV_W-1:0]  o_available;
    logic              o_report;
    logic [IDX_W-1:0]  o_trim;
    logic              o_pending;

    status_t           status_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [REV_W-1:0]  record_reg;
    logic [REV_W-1:0]  expected_reg;
    logic [REV_W-1:0]  available_reg;
    logic              report_reg;
    logic [IDX_W-1:0]  trim_reg;
    logic              pending_reg;

    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  span;
    logic [REV_W:0]    diff;
    logic [REV_W-1:0]  trim_key;
    logic [CNT_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic              we;
    logic [REV_W-1:0]  rdata;
    logic              full;
    logic [CNT_W-1:0]  drop_ext;
    logic [CNT_W-1:0]  drop_sat;
    logic [REV_W:0]    expected;
    logic              missing;

    assign span     = hi_reg - lo_reg;
    assign mid      = lo_reg + (span >> 1);
    assign diff     = {1'b0, rev_reg} - {1'b0, maxr_reg};
    assign trim_key = diff[REV_W] ? '0 : diff[REV_W-1:0];

    always_comb begin
        case ({cmd.rd_last, cmd.rd_idx})
            2'b10:   rd_pos = count_reg - CNT_W'(1);
            2'b01:   rd_pos = lo_reg;
            default: rd_pos = mid;
        endcase
    end

    assign re    = cmd.rd_mid | cmd.rd_idx | cmd.rd_last;
    assign raddr = head_reg + rd_pos[ADDR_W-1:0];
    assign waddr = head_reg + count_reg[ADDR_W-1:0];
    assign full  = (count_reg == CNT_W'(LOG_DEPTH));
    assign we    = cmd.commit && (mode_reg == MODE_APPEND) && !full;

    rlrc_ram #(
        .WIDTH (REV_W),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (rev_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign drop_ext = CNT_W'(drop_reg);
    assign drop_sat = (drop_ext > count_reg) ? count_reg : drop_ext;
    assign expected = {1'b0, cursor_reg} + (REV_W+1)'(1);

    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        reported_next = reported_reg;
        o_status      = STATUS_NONE;
        o_index       = '0;
        o_record      = '0;
        o_expected    = '0;
        o_available   = '0;
        o_report      = 1'b0;
        o_trim        = '0;
        o_pending     = 1'b0;
        missing       = 1'b0;
        case (mode_reg)
            MODE_APPEND: begin
                if (full) begin
                    o_status = STATUS_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_DROP: begin
                head_next  = head_reg + drop_sat[ADDR_W-1:0];
                count_next = count_reg - drop_sat;
            end
            MODE_TRIM: begin
                if (maxr_reg != '0) o_trim = IDX_W'(lo_reg);
            end
            MODE_NEXT: begin
                if (lo_reg < count_reg) begin
                    if ({1'b0, rdata} == expected) begin
                        o_status = STATUS_READY;
                        o_index  = IDX_W'(lo_reg);
                        o_record = rdata;
                    end else begin
                        o_status    = STATUS_GAP;
                        o_available = rdata;
                        missing     = 1'b1;
                    end
                end else if ({1'b0, rev_reg} >= expected) begin
                    o_status    = STATUS_UNAVAIL;
                    o_available = rev_reg;
                    missing     = 1'b1;
                end
                if (missing) begin
                    o_expected    = expected[REV_W-1:0];
                    o_report      = (reported_reg != expected[REV_W-1:0]);
                    reported_next = expected[REV_W-1:0];
                end
            end
            MODE_APPLIED: begin
                cursor_next   = rev_reg;
                reported_next = '0;
            end
            MODE_PENDING: begin
                o_pending = (rev_reg > cursor_reg) ||
                            ((count_reg != '0) && (rdata > cursor_reg));
            end
            default: begin
                o_status = STATUS_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            count_reg    <= '0;
            cursor_reg   <= '0;
            reported_reg <= '0;
            valid_reg    <= 1'b0;
            mode_reg     <= MODE_APPEND;
        end else begin
            if (cmd.latch_in) mode_reg <= mode_t'(s_tuser);
            if (cmd.commit) begin
                head_reg     <= head_next;
                count_reg    <= count_next;
                cursor_reg   <= cursor_next;
                reported_reg <= reported_next;
                valid_reg    <= 1'b1;
            end else if (m_tready) begin
                valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            rev_reg  <= s_tdata[REV_W-1:0];
            maxr_reg <= s_tdata[2*REV_W-1:REV_W];
            drop_reg <= s_tdata[2*REV_W+IDX_W-1:2*REV_W];
        end
        if (cmd.search_init) begin
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            key_reg <= (mode_reg == MODE_TRIM) ? trim_key : cursor_reg;
        end
        if (cmd.rd_mid) mid_reg <= mid;
        if (cmd.step) begin
            if (rdata <= key_reg) begin
                lo_reg <= mid_reg + CNT_W'(1);
            end else begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.commit) begin
            status_reg    <= o_status;
            index_reg     <= o_index;
            record_reg    <= o_record;
            expected_reg  <= o_expected;
            available_reg <= o_available;
            report_reg    <= o_report;
            trim_reg      <= o_trim;
            pending_reg   <= o_pending;
        end
    end

    assign stat.mode        = mode_reg;
    assign stat.search_done = (lo_reg >= hi_reg);
    assign stat.trim_zero   = (maxr_reg == '0);
    assign stat.out_free    = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, pending_reg, trim_reg, report_reg, available_reg,
                       expected_reg, record_reg, index_reg};

endmodule
`default_nettype wire

// ----- hdl/revision_log_replay_cursor.sv -----
// Top level of the revision log replay cursor: controller plus datapath.
// Depends on rlrc_pkg, rlrc_ctrl and rlrc_dp (which holds rlrc_ram).
// Append, drop, applied, pending and zero-trim go from transfer through decode to commit.
// Trim and next edit add a binary search before commit: each probe is a RAM read, then a compare.
// A new item is accepted only after the last result commits; a search makes P <= 9 probes.
// Reset clears pointers, cursor, report mark and handshake; log contents are left unwritten.
`default_nettype none
module revision_log_replay_cursor
    import rlrc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // revision[30:0], max_records[61:31], drop_count[70:62], zero pad[71]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // mode[2:0]
    input  wire logic [MODE_W-1:0]   s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // record_index[8:0], record_revision[39:9], expected_revision[70:40],
    // available_revision[101:71], should_report[102], trim_count[111:103],
    // pending[112], zero pad[119:113]
    output logic      [M_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic      [STAT_W-1:0]   m_tuser
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    rlrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rlrc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ----- hdl/rlrc_checker.sv -----
// Port-level checker for revision_log_replay_cursor, bound to the top level.
// Depends on rlrc_pkg.
`default_nettype none
module rlrc_checker
    import rlrc_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic [MODE_W-1:0]   s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [STAT_W-1:0]   m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new transfer taken while an item is in work");

    a_ready_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_READY) |->
            (m_tdata[70:40] == '0) && (m_tdata[101:71] == '0) && !m_tdata[102])
        else $error("ready result carries gap fields");

endmodule

bind revision_log_replay_cursor rlrc_checker u_rlrc_checker (.*);
`default_nettype wire

// ----- bench/revision_log_replay_cursor_tb.sv -----
// Self-checking bench for revision_log_replay_cursor: streams edit-log commands in bursts
// and checks every reply against an in-bench replay-cursor model. Depends on rlrc_pkg.
`timescale 1ns / 1ps
module revision_log_replay_cursor_tb
    import rlrc_pkg::*;
();

    typedef struct {
        mode_t              mode;
        logic [REV_W-1:0]   rev;
        logic [REV_W-1:0]   max_rec;
        logic [IDX_W-1:0]   drop;
        bit                 drain_first;
    } edit_cmd_t;

    typedef struct {
        status_t            status;
        logic [IDX_W-1:0]   rec_idx;
        logic [REV_W-1:0]   rec_rev;
        logic [REV_W-1:0]   exp_rev;
        logic [REV_W-1:0]   avail_rev;
        logic               report;
        logic [IDX_W-1:0]   trim;
        logic               pend;
    } cursor_reply_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]   m_tuser;

    revision_log_replay_cursor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    edit_cmd_t     command_q[$];
    cursor_reply_t reply_q[$];
    int            errors       = 0;
    int            items_sent   = 0;
    int            results_seen = 0;
    bit            drain_next   = 1'b0;

    logic [REV_W-1:0] log_mem [LOG_DEPTH];
    logic [ADDR_W-1:0] log_head         = '0;
    logic [CNT_W-1:0]  log_count        = '0;
    logic [REV_W-1:0]  applied_cursor   = '0;
    logic [REV_W-1:0]  reported_missing = '0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic queue_cmd(input mode_t m, input logic [REV_W-1:0] r = '0,
                             input logic [REV_W-1:0] mx = '0, input logic [IDX_W-1:0] d = '0);
        edit_cmd_t c;
        c.mode        = m;
        c.rev         = r;
        c.max_rec     = mx;
        c.drop        = d;
        c.drain_first = drain_next;
        drain_next    = 1'b0;
        command_q.push_back(c);
    endtask

    function automatic logic [REV_W-1:0] log_entry(input int pos);
        return log_mem[ADDR_W'((int'(log_head) + pos) % LOG_DEPTH)];
    endfunction

    function automatic int find_above(input longint key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = int'(log_count);
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (longint'(log_entry(mid)) <= key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic cursor_reply_t apply_command(input edit_cmd_t c);
        cursor_reply_t    rp;
        logic [IDX_W-1:0] d;
        longint           keep;
        int               idx;
        logic [31:0]      next_rev;
        logic [REV_W-1:0] found;
        bit               missing;
        rp = '{STATUS_NONE, '0, '0, '0, '0, 1'b0, '0, 1'b0};
        missing = 1'b0;
        case (c.mode)
            MODE_APPEND: begin
                if (log_count >= CNT_W'(LOG_DEPTH)) begin
                    rp.status = STATUS_FULL;
                end else begin
                    log_mem[ADDR_W'((int'(log_head) + int'(log_count)) % LOG_DEPTH)] = c.rev;
                    log_count = log_count + 1'b1;
                end
            end
            MODE_DROP: begin
                d = (c.drop > log_count) ? log_count : c.drop;
                log_head  = ADDR_W'((int'(log_head) + int'(d)) % LOG_DEPTH);
                log_count = log_count - d;
            end
            MODE_TRIM: begin
                if (c.max_rec != '0) begin
                    keep = longint'(c.rev) - longint'(c.max_rec) + 1;
                    if (keep < 1)
                        keep = 1;
                    rp.trim = IDX_W'(find_above(keep - 1));
                end
            end
            MODE_NEXT: begin
                idx      = find_above(longint'(applied_cursor));
                next_rev = applied_cursor + 32'd1;
                if (idx < int'(log_count)) begin
                    found = log_entry(idx);
                    if ({1'b0, found} == next_rev) begin
                        rp.status  = STATUS_READY;
                        rp.rec_idx = IDX_W'(idx);
                        rp.rec_rev = found;
                    end else begin
                        rp.status    = STATUS_GAP;
                        rp.avail_rev = found;
                        missing      = 1'b1;
                    end
                end else if ({1'b0, c.rev} >= next_rev) begin
                    rp.status    = STATUS_UNAVAIL;
                    rp.avail_rev = c.rev;
                    missing      = 1'b1;
                end
                if (missing) begin
                    rp.exp_rev       = next_rev[REV_W-1:0];
                    rp.report        = (reported_missing != next_rev[REV_W-1:0]);
                    reported_missing = next_rev[REV_W-1:0];
                end
            end
            MODE_APPLIED: begin
                applied_cursor   = c.rev;
                reported_missing = '0;
            end
            MODE_PENDING: begin
                rp.pend = (c.rev > applied_cursor) ||
                          (log_count != '0 && log_entry(int'(log_count) - 1) > applied_cursor);
            end
            default: begin
            end
        endcase
        return rp;
    endfunction

    task automatic check_field(input string name, input logic [REV_W-1:0] want,
                               input logic [REV_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Sender: bursts of random length, gaps between them, drain hold where flagged.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        logic fire;
        int   in_flight;
        fire = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (fire) begin
                reply_q.push_back(apply_command(command_q.pop_front()));
                items_sent <= items_sent + 1;
            end
            in_flight = items_sent + int'(fire) - results_seen;
            if (s_tvalid && !fire) begin
                // hold the offered transfer
            end else if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (command_q.size() == 0 ||
                         (command_q[0].drain_first && in_flight != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, command_q[0].drop, command_q[0].max_rec, command_q[0].rev};
                s_tuser  <= command_q[0].mode;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: stall pattern changes per phase; one long hold-off to back up the input.
    int phase_left = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(16, 128);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cursor_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (reply_q.size() == 0) begin
                $display("%0t unexpected transfer: expected none, actual status %0d data %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = reply_q.pop_front();
                check_field("status", REV_W'(want.status), REV_W'(m_tuser));
                check_field("record_index", REV_W'(want.rec_idx), REV_W'(m_tdata[8:0]));
                check_field("record_revision", want.rec_rev, m_tdata[39:9]);
                check_field("expected_revision", want.exp_rev, m_tdata[70:40]);
                check_field("available_revision", want.avail_rev, m_tdata[101:71]);
                check_field("should_report", REV_W'(want.report), REV_W'(m_tdata[102]));
                check_field("trim_count", REV_W'(want.trim), REV_W'(m_tdata[111:103]));
                check_field("pending", REV_W'(want.pend), REV_W'(m_tdata[112]));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("revision_log_replay_cursor_tb failed");
        $finish;
    end

    initial begin
        int               g_count;
        logic [REV_W-1:0] g_next_rev;
        logic [REV_W-1:0] g_cursor;
        logic [REV_W-1:0] r;
        logic [REV_W-1:0] mx;
        logic [IDX_W-1:0] d;
        mode_t            m;
        bit               fill_done;
        int               n;
        int               base;

        // empty log: nothing, unavailable reported once, pending and trim on empty
        queue_cmd(MODE_NEXT, 31'd0);
        queue_cmd(MODE_NEXT, 31'h7fffffff);
        queue_cmd(MODE_NEXT, 31'd5);
        queue_cmd(MODE_PENDING, 31'd0);
        queue_cmd(MODE_PENDING, 31'd1);
        queue_cmd(MODE_TRIM, 31'd10, 31'd0);
        queue_cmd(MODE_TRIM, 31'd10, 31'd3);
        queue_cmd(MODE_APPEND, 31'd1);
        queue_cmd(MODE_APPEND, 31'd2);
        queue_cmd(MODE_APPEND, 31'd3);
        queue_cmd(MODE_APPEND, 31'd5);
        // ready twice, then a gap reported once
        queue_cmd(MODE_NEXT, 31'd0);
        queue_cmd(MODE_APPLIED, 31'd1);
        queue_cmd(MODE_NEXT, 31'd0);
        queue_cmd(MODE_APPLIED, 31'd3);
        queue_cmd(MODE_NEXT, 31'd9);
        queue_cmd(MODE_NEXT, 31'd9);
        // trim bounds: ordinary, clamped to one, top of range
        queue_cmd(MODE_TRIM, 31'd5, 31'd2);
        queue_cmd(MODE_TRIM, 31'd0, 31'h7fffffff);
        queue_cmd(MODE_TRIM, 31'h7fffffff, 31'd1);
        queue_cmd(MODE_PENDING, 31'd0);
        queue_cmd(MODE_APPEND, 31'd4);
        queue_cmd(MODE_DROP, 31'd0, 31'd0, 9'd2);
        // cursor at the top of the range never matches
        queue_cmd(MODE_APPLIED, 31'h7fffffff);
        queue_cmd(MODE_NEXT, 31'h7fffffff);
        queue_cmd(MODE_DROP, 31'h7fffffff, 31'h7fffffff, 9'd256);
        queue_cmd(MODE_APPLIED, 31'd0);

        g_count    = 0;
        g_next_rev = 31'd1;
        g_cursor   = '0;
        fill_done  = 1'b0;
        drain_next = 1'b1;
        base       = command_q.size();
        while (command_q.size() < base + 1000) begin
            if ($urandom_range(0, 49) == 0)
                drain_next = 1'b1;
            n = $urandom_range(0, 99);
            if (!fill_done && command_q.size() > base + 400) begin
                fill_done = 1'b1;
                while (g_count < LOG_DEPTH + 2) begin
                    queue_cmd(MODE_APPEND, g_next_rev);
                    g_next_rev = g_next_rev +
                                 REV_W'(($urandom_range(0, 9) == 0) ? 2 : 1);
                    g_count++;
                end
                g_count = LOG_DEPTH;
                queue_cmd(MODE_NEXT, g_next_rev);
                queue_cmd(MODE_TRIM, g_next_rev, 31'd100);
            end else if (n < 40) begin
                repeat ($urandom_range(1, 8)) begin
                    queue_cmd(MODE_APPEND, g_next_rev);
                    if (g_count < LOG_DEPTH)
                        g_count++;
                    g_next_rev = g_next_rev + REV_W'(($urandom_range(0, 7) == 0) ?
                                                     $urandom_range(2, 4) : 1);
                end
            end else if (n < 65) begin
                if ($urandom_range(0, 5) == 0) begin
                    r = REV_W'($urandom_range(1, 3 * g_count + 2));
                    g_cursor = (g_next_rev > r) ? g_next_rev - r : '0;
                    queue_cmd(MODE_APPLIED, g_cursor);
                end
                repeat ($urandom_range(1, 6)) begin
                    queue_cmd(MODE_NEXT, REV_W'(g_next_rev - 1 + $urandom_range(0, 2)));
                    if ($urandom_range(0, 3) != 0) begin
                        g_cursor = g_cursor + REV_W'(1);
                        queue_cmd(MODE_APPLIED, g_cursor);
                    end
                end
            end else if (n < 75) begin
                d = ($urandom_range(0, 9) == 0) ? 9'd256 : IDX_W'($urandom_range(0, 16));
                queue_cmd(MODE_DROP, '0, '0, d);
                g_count = (int'(d) > g_count) ? 0 : g_count - int'(d);
            end else if (n < 83) begin
                case ($urandom_range(0, 3))
                    0: mx = '0;
                    1: mx = REV_W'($urandom);
                    default: mx = REV_W'($urandom_range(1, 300));
                endcase
                queue_cmd(MODE_TRIM, REV_W'(g_next_rev - $urandom_range(0, 5)), mx);
            end else if (n < 88) begin
                queue_cmd(MODE_PENDING, REV_W'(g_cursor - 1 + $urandom_range(0, 2)));
            end else begin
                m = mode_t'($urandom_range(0, 5));
                case ($urandom_range(0, 3))
                    0: r = REV_W'($urandom);
                    1: r = REV_W'(31'h7fffffff - $urandom_range(0, 3));
                    2: r = REV_W'($urandom_range(0, 3));
                    default: r = REV_W'(g_next_rev + $urandom_range(0, 3));
                endcase
                mx = ($urandom_range(0, 1) == 0) ? REV_W'($urandom)
                                                 : REV_W'($urandom_range(0, 8));
                d  = IDX_W'($urandom_range(0, 256));
                queue_cmd(m, r, mx, d);
                if (m == MODE_APPEND && g_count < LOG_DEPTH)
                    g_count++;
                else if (m == MODE_DROP)
                    g_count = (int'(d) > g_count) ? 0 : g_count - int'(d);
                else if (m == MODE_APPLIED)
                    g_cursor = r;
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (command_q.size() != 0 || s_tvalid || reply_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("revision_log_replay_cursor_tb passed");
        else
            $display("revision_log_replay_cursor_tb failed");
        $finish;
    end

endmodule
